// ===== rtl/mcb_pkg.sv =====
// ----------------------------------------------------------------------------
// Mask centroid bearing package
// Shared widths, register indexes, controller states and the command and
// status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package mcb_pkg;

  // Frame size limits.
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  // Field and state widths.
  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned ANGLE_W   = 8;
  localparam int unsigned COL_W     = 10;
  localparam int unsigned ROW_W     = 10;
  localparam int unsigned SUM_W     = 30;
  localparam int unsigned CNT_W     = 20;
  localparam int unsigned CENTER_W  = 18;
  localparam int unsigned BEARING_W = 16;

  // Datapath widths for the end-of-frame arithmetic.
  localparam int unsigned PROD_W   = SIZE_W + CNT_W;   // width times count
  localparam int unsigned MAG_W    = 30;               // |2*sum - W*count|
  localparam int unsigned SCALED_W = MAG_W + ANGLE_W;  // magnitude times angle
  localparam int unsigned DIVN_W   = 45;               // dividend
  localparam int unsigned DIVD_W   = 31;               // divisor
  localparam int unsigned QUO_W    = 18;               // quotient bits produced
  localparam int unsigned STEP_W   = 5;                // divider step counter

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = SIZE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_ANGLE   = 2'd2;

  localparam logic [SIZE_W-1:0]  RST_FRAME_WIDTH  = 11'd320;
  localparam logic [SIZE_W-1:0]  RST_FRAME_HEIGHT = 11'd240;
  localparam logic [ANGLE_W-1:0] RST_VIEW_ANGLE   = 8'd47;

  // Stream payload widths.
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 56;
  localparam int unsigned M_TUSER_W = 1;

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_CEN_START,
    ST_CEN_WAIT,
    ST_PROD,
    ST_MAG,
    ST_SCALE,
    ST_BRG_START,
    ST_BRG_WAIT,
    ST_OUT
  } mcb_state_e;

  typedef enum logic {
    DIV_CENTER,
    DIV_BEARING
  } div_sel_e;

  typedef struct packed {
    logic     accept_en;
    logic     div_start;
    div_sel_e div_sel;
    logic     cap_center;
    logic     prod_en;
    logic     mag_en;
    logic     scale_en;
    logic     cap_bearing;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic found;
    logic div_busy;
    logic div_done;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== rtl/mcb_div.sv =====
// ----------------------------------------------------------------------------
// Mask centroid bearing divider
// Restoring divider, one quotient bit per cycle, for dividends whose
// quotient is known to fit QUO_W bits.
// ----------------------------------------------------------------------------
module mcb_div
  import mcb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVN_W-1:0] dividend_i,
  input  logic [DIVD_W-1:0] divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [QUO_W-1:0]  quotient_o
);

  logic [DIVD_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0]  nq_q, nq_d;
  logic [DIVD_W-1:0] den_q;
  logic [STEP_W-1:0] step_q, step_d;
  logic              done_q, done_d;
  logic [DIVD_W:0]   trial;
  logic              qbit;

  assign trial = {rem_q, nq_q[QUO_W-1]};
  assign qbit  = (trial >= {1'b0, den_q});

  always_comb begin
    rem_d  = rem_q;
    nq_d   = nq_q;
    step_d = step_q;
    done_d = 1'b0;
    if (start_i) begin
      // The upper dividend bits are below the divisor since the quotient fits.
      rem_d  = DIVD_W'(dividend_i[DIVN_W-1:QUO_W]);
      nq_d   = dividend_i[QUO_W-1:0];
      step_d = STEP_W'(QUO_W);
    end else if (step_q != '0) begin
      rem_d  = qbit ? DIVD_W'(trial - {1'b0, den_q}) : trial[DIVD_W-1:0];
      nq_d   = {nq_q[QUO_W-2:0], qbit};
      step_d = step_q - 1'b1;
      done_d = (step_q == STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nq_q  <= nq_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign busy_o     = (step_q != '0);
  assign done_o     = done_q;
  assign quotient_o = nq_q;

endmodule

// ===== rtl/mcb_datapath.sv =====
// ----------------------------------------------------------------------------
// Mask centroid bearing datapath
// Configuration registers, pixel counters, lower-half sums, end-of-frame
// arithmetic around a shared divider, and the result register.
// ----------------------------------------------------------------------------
module mcb_datapath
  import mcb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_write_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  pix_valid_i,
  input  logic                  pix_i,
  input  logic                  m_ready_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o,
  output logic                  m_valid_o,
  output logic                  found_o,
  output logic [CENTER_W-1:0]   center_o,
  output logic [BEARING_W-1:0]  bearing_o,
  output logic [CNT_W-1:0]      count_o
);

  logic [SIZE_W-1:0]  width_cfg_q, height_cfg_q;
  logic [ANGLE_W-1:0] angle_q;
  logic [SIZE_W-1:0]  width_eff, height_eff;

  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] cnt_q;

  logic pix_fire, row_end, frame_end, lower_half;

  logic [PROD_W-1:0]   prod_q;
  logic [SUM_W:0]      twice_sum;
  logic [MAG_W-1:0]    mag_q;
  logic                neg_q;
  logic [SCALED_W-1:0] scaled_q;
  logic [CENTER_W-1:0] center_q;
  logic [BEARING_W-1:0] bearing_q;
  logic [BEARING_W-1:0] last_bearing_q;
  logic [BEARING_W-1:0] qmag;

  logic [DIVN_W-1:0] div_num;
  logic [DIVD_W-1:0] div_den;
  logic              div_busy, div_done;
  logic [QUO_W-1:0]  div_quo;

  logic                 m_valid_q;
  logic                 found_q;
  logic [CENTER_W-1:0]  out_center_q;
  logic [BEARING_W-1:0] out_bearing_q;
  logic [CNT_W-1:0]     out_count_q;

  // Configuration registers; index three is not a register and is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg_q  <= RST_FRAME_WIDTH;
      height_cfg_q <= RST_FRAME_HEIGHT;
      angle_q      <= RST_VIEW_ANGLE;
    end else if (cfg_write_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  width_cfg_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: height_cfg_q <= cfg_data_i;
        CFG_VIEW_ANGLE:   angle_q      <= cfg_data_i[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_cfg_q == '0) begin
      width_eff = SIZE_W'(1);
    end else if (width_cfg_q > SIZE_W'(MAX_WIDTH)) begin
      width_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      width_eff = width_cfg_q;
    end
    if (height_cfg_q == '0) begin
      height_eff = SIZE_W'(1);
    end else if (height_cfg_q > SIZE_W'(MAX_HEIGHT)) begin
      height_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      height_eff = height_cfg_q;
    end
  end

  // Pixel counters and lower-half accumulation.
  assign pix_fire   = cmd_i.accept_en && pix_valid_i;
  assign lower_half = ({1'b0, row_q} >= {1'b0, height_eff[SIZE_W-1:1]});
  assign row_end    = ({1'b0, col_q} >= (width_eff - 1'b1));
  assign frame_end  = row_end && ({1'b0, row_q} >= (height_eff - 1'b1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      if (pix_fire) begin
        if (!row_end) begin
          col_q <= col_q + 1'b1;
        end else begin
          col_q <= '0;
          row_q <= frame_end ? '0 : row_q + 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else if (pix_fire && pix_i && lower_half) begin
        sum_q <= sum_q + SUM_W'(col_q);
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // End-of-frame arithmetic, one operation per cycle.
  assign twice_sum = {sum_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_en) begin
      prod_q <= width_eff * cnt_q;
    end
    if (cmd_i.mag_en) begin
      if ({1'b0, twice_sum} >= prod_q) begin
        mag_q <= MAG_W'({1'b0, twice_sum} - prod_q);
        neg_q <= 1'b0;
      end else begin
        mag_q <= MAG_W'(prod_q - {1'b0, twice_sum});
        neg_q <= 1'b1;
      end
    end
    if (cmd_i.scale_en) begin
      scaled_q <= mag_q * angle_q;
    end
    if (cmd_i.cap_center) begin
      center_q <= div_quo;
    end
    if (cmd_i.cap_bearing) begin
      bearing_q <= neg_q ? BEARING_W'(16'd0 - qmag) : qmag;
    end
  end

  assign qmag = (div_quo > QUO_W'(16'h7FFF)) ? 16'h7FFF : div_quo[BEARING_W-1:0];

  // Center: (256*sum + count/2) / count.
  // Bearing: (256*V*|2*sum - W*count| + W*count) / (2*W*count).
  always_comb begin
    if (cmd_i.div_sel == DIV_CENTER) begin
      div_num = DIVN_W'({sum_q, 8'd0}) + DIVN_W'(cnt_q[CNT_W-1:1]);
      div_den = DIVD_W'(cnt_q);
    end else begin
      div_num = {scaled_q[DIVN_W-9:0], 8'd0} + DIVN_W'(prod_q[PROD_W-2:0]);
      div_den = {prod_q[PROD_W-2:0], 1'b0};
    end
  end

  mcb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Result register and remembered bearing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q      <= 1'b0;
      last_bearing_q <= '0;
    end else begin
      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
        if (cnt_q != '0) begin
          last_bearing_q <= bearing_q;
        end
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cnt_q != '0) begin
        found_q       <= 1'b1;
        out_center_q  <= center_q;
        out_bearing_q <= bearing_q;
        out_count_q   <= cnt_q;
      end else begin
        found_q       <= 1'b0;
        out_center_q  <= '0;
        out_bearing_q <= last_bearing_q;
        out_count_q   <= '0;
      end
    end
  end

  // The last pixel of the frame is counted at the same edge, so it is
  // included here directly.
  assign status_o.frame_end = pix_fire && frame_end;
  assign status_o.found     = (cnt_q != '0) || (pix_i && lower_half);
  assign status_o.div_busy  = div_busy;
  assign status_o.div_done  = div_done;
  assign status_o.out_busy  = m_valid_q && !m_ready_i;

  assign m_valid_o = m_valid_q;
  assign found_o   = found_q;
  assign center_o  = out_center_q;
  assign bearing_o = out_bearing_q;
  assign count_o   = out_count_q;

endmodule

// ===== rtl/mcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Mask centroid bearing controller
// Sequences pixel intake and the end-of-frame center and bearing divisions.
// ----------------------------------------------------------------------------
module mcb_ctrl
  import mcb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  mcb_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACCUM: begin
        if (status_i.frame_end) begin
          state_d = status_i.found ? ST_CEN_START : ST_OUT;
        end
      end
      ST_CEN_START: state_d = ST_CEN_WAIT;
      ST_CEN_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_PROD;
        end
      end
      ST_PROD:      state_d = ST_MAG;
      ST_MAG:       state_d = ST_SCALE;
      ST_SCALE:     state_d = ST_BRG_START;
      ST_BRG_START: state_d = ST_BRG_WAIT;
      ST_BRG_WAIT: begin
        if (status_i.div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!status_i.out_busy) begin
          state_d = ST_ACCUM;
        end
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.div_sel = DIV_CENTER;
    case (state_q)
      ST_ACCUM:     cmd_o.accept_en = 1'b1;
      ST_CEN_START: cmd_o.div_start = 1'b1;
      ST_CEN_WAIT:  cmd_o.cap_center = status_i.div_done;
      ST_PROD:      cmd_o.prod_en = 1'b1;
      ST_MAG:       cmd_o.mag_en = 1'b1;
      ST_SCALE:     cmd_o.scale_en = 1'b1;
      ST_BRG_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_BEARING;
      end
      ST_BRG_WAIT: begin
        cmd_o.div_sel     = DIV_BEARING;
        cmd_o.cap_bearing = status_i.div_done;
      end
      ST_OUT:       cmd_o.out_load = !status_i.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_stall_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.frame_end |=> !cmd_o.accept_en)
    else $error("pixel intake not stopped after frame end");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !status_i.out_busy)
    else $error("result register overwritten while held");

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !status_i.div_busy)
    else $error("divider started while busy");

  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == ST_CEN_WAIT || state_q == ST_BRG_WAIT))
    else $error("divider finished outside a wait state");
`endif

endmodule

// ===== rtl/mask_centroid_bearing.sv =====
// ----------------------------------------------------------------------------
// Mask centroid bearing
// Horizontal centroid and bearing angle of the lower half of a binary mask.
// ----------------------------------------------------------------------------
// Pixels of a thresholded mask enter one word per clock in raster order on the
// slave stream, with the pixel in bit 0 of tdata. The block counts columns and
// rows itself against the frame_width and frame_height registers (clamped to
// 1..1024) and, for set pixels in rows at or below half the height, sums the
// column index and counts the pixels. After the last pixel of a frame it
// emits one result word: the centroid column in Q8, the bearing in degrees Q8
// computed as (centroid - width/2) * view_angle / width rounded to nearest,
// and the pixel count, with tuser flagging whether any pixel was found. A
// frame without pixels reports zeros and repeats the last bearing. Pixels are
// taken at one per cycle during a frame. After the last pixel of a frame with
// pixels the intake stops while one shared restoring divider produces the
// center and then the bearing at one quotient bit per cycle (18 steps each)
// with a multiply, a subtract and a multiply between them; a frame without
// pixels stops intake only in the output state. A result waiting in the output
// register does not hold up the next frame's pixels, but the next frame's
// result is not loaded, nor intake resumed, until the previous one is taken.
// ----------------------------------------------------------------------------
module mask_centroid_bearing
  import mcb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  // Pixel stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [0] mask_pixel, [7:1] zero

  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [17:0] center_column_q8, [33:18] bearing_q8, [53:34] hit_count,
  // [55:54] zero
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  output logic [M_TUSER_W-1:0]  m_axis_tuser    // [0] target_found
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  logic                 found;
  logic [CENTER_W-1:0]  center_column_q8;
  logic [BEARING_W-1:0] bearing_q8;
  logic [CNT_W-1:0]     hit_count;

  // Registers can be written at any time; writes are expected only when idle.
  assign cfg_ready_o = 1'b1;

  mcb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  mcb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_valid_i (s_axis_tvalid),
    .pix_i       (s_axis_tdata[0]),
    .m_ready_i   (m_axis_tready),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_valid_o   (m_axis_tvalid),
    .found_o     (found),
    .center_o    (center_column_q8),
    .bearing_o   (bearing_q8),
    .count_o     (hit_count)
  );

  assign s_axis_tready = cmd.accept_en;
  assign m_axis_tdata  = {2'b00, hit_count, bearing_q8, center_column_q8};
  assign m_axis_tuser  = found;

endmodule
